/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, ignored while reset is high.
`define DXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock that also holds during reset.
`define DXT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dxt_pkg.sv */
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared constants of the texture block decoder: format codes, register map
// and arithmetic constants of the palette builders.
// ----------------------------------------------------------------------------
`default_nettype none

package dxt_pkg;

  // Format register.
  localparam int          FMT_W      = 2;
  localparam logic [1:0]  FMT_DXT1   = 2'd0;
  localparam logic [1:0]  FMT_DXT3   = 2'd1;
  localparam logic [1:0]  FMT_DXT5   = 2'd2;

  // Register map: one register, word aligned.
  localparam int          PADDR_W    = 3;
  localparam logic        REG_FORMAT = 1'b0;

  // Texel counting.
  localparam logic [3:0]  LAST_TEXEL = 4'd15;

  // Color blend factors for the one-third and two-thirds entries.
  localparam logic [7:0]  BLEND_1_3  = 8'h55;
  localparam logic [7:0]  BLEND_2_3  = 8'haa;

  // Reciprocals for dividing the alpha numerators by 7 and by 5.
  localparam int          RECIP_SHIFT = 14;
  localparam logic [11:0] RECIP7      = 12'd2341;
  localparam logic [11:0] RECIP5      = 12'd3277;

endpackage

`default_nettype wire

/* design/dxt_block_decoder_unit.sv */
// ----------------------------------------------------------------------------
// dxt_block_decoder_unit
// Decodes one 4x4 DXT1/DXT3/DXT5 block per command into sixteen texels.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. Its sixteen texels
// leave in raster order, one per cycle, each marked by texel_valid for one
// cycle; last_texel flags the sixteenth. There is no back pressure on the
// texel side: the receiver must take each texel beat in the cycle it is shown.
// A block passes stages 1 to 4, the texel serializer and the output register.
// The serializer emits one texel per cycle and loads the next block as the
// last texel of the previous one leaves; while it is full the four palette
// stages fill up behind it and busy rises. Blocks may be started while texels
// of earlier blocks are still leaving. The format register is read when a
// block is accepted and should only be changed while no block is in flight.
`default_nettype none

module dxt_block_decoder_unit (
  input  wire                         clk,
  input  wire                         rst,
  // Command channel.
  input  wire                         start,
  output logic                        busy,
  input  wire  [63:0]                 color_block,
  input  wire  [63:0]                 alpha_block,
  // Texel channel.
  output logic                        texel_valid,
  output logic [3:0]                  texel_index,
  output logic [7:0]                  blue,
  output logic [7:0]                  green,
  output logic [7:0]                  red,
  output logic [7:0]                  alpha,
  output logic                        last_texel,
  // Register port.
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [dxt_pkg::PADDR_W-1:0] paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import dxt_pkg::*;

  // --------------------------------------------------------------------------
  // Register port.
  // --------------------------------------------------------------------------
  logic [FMT_W-1:0] texture_format;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_FORMAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_DXT1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      texture_format <= pwdata[FMT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(32-FMT_W){1'b0}}, texture_format};
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A stage takes new data when it is empty or moves on.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;
  logic ser_active;
  logic [3:0] ser_cnt;
  logic ser_free;
  logic ser_load;
  logic accept;

  assign ser_free = !ser_active || (ser_cnt == LAST_TEXEL);
  assign ser_load = v4 && ser_free;
  assign ready4   = !v4 || ser_free;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign busy     = !ready1;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= accept;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the block and the format.
  // --------------------------------------------------------------------------
  logic [63:0]      s1_cblk;
  logic [63:0]      s1_ablk;
  logic [FMT_W-1:0] s1_fmt;

  always_ff @(posedge clk) begin
    if (ready1 && accept) begin
      s1_cblk <= color_block;
      s1_ablk <= alpha_block;
      s1_fmt  <= texture_format;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: expand the endpoints to 8 bits and form the alpha numerators.
  // Channel 0 is blue, 1 is green, 2 is red.
  // --------------------------------------------------------------------------
  logic [15:0] e0, e1;
  logic [7:0]  a0, a1;
  logic [7:0]  p0_next [3];
  logic [7:0]  p1_next [3];
  logic [10:0] num7_next [2:7];
  logic [10:0] num5_next [2:5];

  assign e0 = s1_cblk[15:0];
  assign e1 = s1_cblk[31:16];
  assign a0 = s1_ablk[7:0];
  assign a1 = s1_ablk[15:8];

  // RGB565 to 8 bits per channel by bit replication.
  always_comb begin
    p0_next[0] = {e0[4:0], e0[4:2]};
    p0_next[1] = {e0[10:5], e0[10:9]};
    p0_next[2] = {e0[15:11], e0[15:13]};
    p1_next[0] = {e1[4:0], e1[4:2]};
    p1_next[1] = {e1[10:5], e1[10:9]};
    p1_next[2] = {e1[15:11], e1[15:13]};
  end

  // Weighted alpha sums for the eight-step and six-step ramps.
  always_comb begin
    for (int c = 2; c < 8; c++) begin
      num7_next[c] = 11'(11'(8 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1});
    end
    for (int c = 2; c < 6; c++) begin
      num5_next[c] = 11'(11'(6 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1});
    end
  end

  logic [7:0]       s2_p0 [3];
  logic [7:0]       s2_p1 [3];
  logic [10:0]      s2_num7 [2:7];
  logic [10:0]      s2_num5 [2:5];
  logic [7:0]       s2_a0, s2_a1;
  logic             s2_four;
  logic             s2_le;
  logic [31:0]      s2_idx;
  logic [63:0]      s2_ablk;
  logic [FMT_W-1:0] s2_fmt;

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      s2_p0   <= p0_next;
      s2_p1   <= p1_next;
      s2_num7 <= num7_next;
      s2_num5 <= num5_next;
      s2_a0   <= a0;
      s2_a1   <= a1;
      s2_four <= (e0 > e1) || (s1_fmt == FMT_DXT5);
      s2_le   <= (e0 <= e1);
      s2_idx  <= s1_cblk[63:32];
      s2_ablk <= s1_ablk;
      s2_fmt  <= s1_fmt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: blend products per channel and the alpha ramp by reciprocals.
  // --------------------------------------------------------------------------
  logic signed [17:0] t2_next [3];
  logic signed [17:0] t3_next [3];
  logic [7:0]         apal_next [8];
  logic [22:0]        q7 [2:7];
  logic [22:0]        q5 [2:5];

  always_comb begin
    logic signed [17:0] d;
    for (int ch = 0; ch < 3; ch++) begin
      d = $signed({10'd0, s2_p1[ch]}) - $signed({10'd0, s2_p0[ch]});
      t2_next[ch] = d * $signed({10'd0, BLEND_1_3}) + 18'sd128;
      t3_next[ch] = d * $signed({10'd0, BLEND_2_3}) + 18'sd128;
    end
  end

  always_comb begin
    for (int c = 2; c < 8; c++) begin
      q7[c] = {12'd0, s2_num7[c]} * {11'd0, RECIP7};
    end
    for (int c = 2; c < 6; c++) begin
      q5[c] = {12'd0, s2_num5[c]} * {11'd0, RECIP5};
    end
    apal_next[0] = s2_a0;
    apal_next[1] = s2_a1;
    if (s2_a0 > s2_a1) begin
      for (int c = 2; c < 8; c++) begin
        apal_next[c] = q7[c][RECIP_SHIFT +: 8];
      end
    end else begin
      for (int c = 2; c < 6; c++) begin
        apal_next[c] = q5[c][RECIP_SHIFT +: 8];
      end
      apal_next[6] = 8'd0;
      apal_next[7] = 8'd255;
    end
  end

  logic [7:0]         s3_p0 [3];
  logic [7:0]         s3_p1 [3];
  logic signed [17:0] s3_t2 [3];
  logic signed [17:0] s3_t3 [3];
  logic [7:0]         s3_apal [8];
  logic               s3_four;
  logic               s3_le;
  logic [31:0]        s3_idx;
  logic [63:0]        s3_ablk;
  logic [FMT_W-1:0]   s3_fmt;

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      s3_p0   <= s2_p0;
      s3_p1   <= s2_p1;
      s3_t2   <= t2_next;
      s3_t3   <= t3_next;
      s3_apal <= apal_next;
      s3_four <= s2_four;
      s3_le   <= s2_le;
      s3_idx  <= s2_idx;
      s3_ablk <= s2_ablk;
      s3_fmt  <= s2_fmt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round the blends and settle the four-entry color palette.
  // --------------------------------------------------------------------------
  logic [7:0] pal_next [4][3];

  always_comb begin
    logic signed [17:0] m2, m3;
    logic [8:0]         avg;
    for (int ch = 0; ch < 3; ch++) begin
      m2  = (s3_t2[ch] + (s3_t2[ch] >>> 8)) >>> 8;
      m3  = (s3_t3[ch] + (s3_t3[ch] >>> 8)) >>> 8;
      avg = ({1'b0, s3_p0[ch]} + {1'b0, s3_p1[ch]} + 9'd1) >> 1;
      pal_next[0][ch] = s3_p0[ch];
      pal_next[1][ch] = s3_p1[ch];
      if (s3_four) begin
        pal_next[2][ch] = s3_p0[ch] + m2[7:0];
        pal_next[3][ch] = s3_p0[ch] + m3[7:0];
      end else begin
        pal_next[2][ch] = avg[7:0];
        pal_next[3][ch] = 8'd255;
      end
    end
  end

  logic [7:0]       s4_pal [4][3];
  logic [7:0]       s4_apal [8];
  logic             s4_le;
  logic [31:0]      s4_idx;
  logic [63:0]      s4_ablk;
  logic [FMT_W-1:0] s4_fmt;

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      s4_pal  <= pal_next;
      s4_apal <= s3_apal;
      s4_le   <= s3_le;
      s4_idx  <= s3_idx;
      s4_ablk <= s3_ablk;
      s4_fmt  <= s3_fmt;
    end
  end

  // --------------------------------------------------------------------------
  // Texel serializer: holds one decoded block and walks its sixteen texels.
  // --------------------------------------------------------------------------
  logic [7:0]       ser_pal [4][3];
  logic [7:0]       ser_apal [8];
  logic             ser_le;
  logic [31:0]      ser_idx;
  logic [63:0]      ser_ablk;
  logic [FMT_W-1:0] ser_fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_active <= 1'b0;
      ser_cnt    <= '0;
    end else if (ser_load) begin
      ser_active <= 1'b1;
      ser_cnt    <= '0;
    end else if (ser_active) begin
      ser_cnt <= ser_cnt + 4'd1;
      if (ser_cnt == LAST_TEXEL) begin
        ser_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_pal  <= s4_pal;
      ser_apal <= s4_apal;
      ser_le   <= s4_le;
      ser_idx  <= s4_idx;
      ser_ablk <= s4_ablk;
      ser_fmt  <= s4_fmt;
    end
  end

  // Select the current texel's color and alpha.
  logic [1:0] cur_idx;
  logic [3:0] cur_nib;
  logic [5:0] code_pos;
  logic [2:0] cur_code;
  logic [7:0] alpha_next;

  assign cur_idx  = ser_idx[{ser_cnt, 1'b0} +: 2];
  assign cur_nib  = ser_ablk[{ser_cnt, 2'b00} +: 4];
  assign code_pos = 6'd16 + {1'b0, ser_cnt, 1'b0} + {2'b00, ser_cnt};
  assign cur_code = ser_ablk[code_pos +: 3];

  always_comb begin
    case (ser_fmt)
      FMT_DXT3: alpha_next = {cur_nib, cur_nib};
      FMT_DXT5: alpha_next = ser_apal[cur_code];
      default:  alpha_next = (ser_le && (cur_idx == 2'd3)) ? 8'd0 : 8'd255;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: one texel beat per cycle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= ser_active;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_active) begin
      texel_index <= ser_cnt;
      blue        <= ser_pal[cur_idx][0];
      green       <= ser_pal[cur_idx][1];
      red         <= ser_pal[cur_idx][2];
      alpha       <= alpha_next;
      last_texel  <= (ser_cnt == LAST_TEXEL);
    end
  end

endmodule

`default_nettype wire

/* design/dxt_checker.sv */
// ----------------------------------------------------------------------------
// dxt_checker
// Port-level checks of the texel sequence of the block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dxt_checker (
  input wire       clk,
  input wire       rst,
  input wire       busy,
  input wire       texel_valid,
  input wire [3:0] texel_index,
  input wire       last_texel
);

  import dxt_pkg::*;

  // The last flag marks exactly the final texel position.
  `DXT_ASSERT(a_last_pos, (texel_valid |-> (last_texel == (texel_index == LAST_TEXEL))), "last_texel does not match texel_index")

  // Within a block the texels follow each other without a gap.
  `DXT_ASSERT(a_next_texel, (texel_valid && !last_texel |=> texel_valid && (texel_index == $past(texel_index) + 4'd1)), "texel sequence broken within a block")

  // A block that follows an idle output starts at the first texel position.
  `DXT_ASSERT(a_first_texel, (texel_valid && !$past(texel_valid) |-> texel_index == 4'd0), "block does not start at texel zero")

  // Reset empties the pipeline and the output.
  `DXT_ASSERT_RST(a_reset, (rst |=> !texel_valid && !busy), "decoder not empty after reset")

endmodule

bind dxt_block_decoder_unit dxt_checker u_dxt_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .texel_valid (texel_valid),
  .texel_index (texel_index),
  .last_texel  (last_texel)
);

`default_nettype wire
